[sv/bba_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package bba_pkg;

   localparam int MAX_BASIC_BLOCKS_DEF = 256;
   localparam int MAX_ORDERS_DEF       = 9;
   localparam int HEADER_BYTES_DEF     = 16;

   localparam int TAG_W    = 6;
   localparam int ORD_W    = 4;
   localparam int SHIFT_W  = 5;
   localparam int ADDR_W   = 24;
   localparam int STATUS_W = 2;

   // tag layout: start, free, order
   localparam int TAG_START_BIT = 5;
   localparam int TAG_FREE_BIT  = 4;

   localparam logic [SHIFT_W-1:0] SHIFT_MIN = 5'd5;
   localparam logic [SHIFT_W-1:0] SHIFT_MAX = 5'd16;

   // csr register index
   localparam logic REG_SHIFT  = 1'b0;
   localparam logic REG_ORDERS = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_TOO_LARGE = 2'd1,
      STATUS_NO_BLOCK  = 2'd2,
      STATUS_BAD_FREE  = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_A_PREP,
      ST_A_EVAL,
      ST_A_END,
      ST_A_SPLIT,
      ST_F_PREP,
      ST_F_CHECK,
      ST_F_LOOP,
      ST_F_MERGE,
      ST_F_WRITE
   } state_type;

endpackage

`default_nettype wire

[sv/bba_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module bba_ram #(
   parameter int WIDTH = 6,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[sv/buddy_block_allocator.sv]
`timescale 1ns / 1ps
`default_nettype none

// Binary buddy allocator over a pool of basic blocks.
// Requests: drive req_mode (0 allocate, 1 free), req_request_bytes or
// req_block_address and pulse start while busy is low; the transaction is
// taken on that edge. Exactly one result per transaction comes back as a
// one-cycle rsp_valid pulse with rsp_data_address and rsp_status. The
// receiver cannot stall: it must take the result in that cycle.
// An allocate walks the pool block by block through the tag RAM, one tag
// per cycle, then writes one tag per split. A free decodes the address,
// reads its tag, then merges with an equal-order free buddy one order at a
// time and writes the merged tag. A request that is too large, a bad free
// or a pool with no free block answers with its error status. One
// transaction is in flight at a time and busy covers it.
// Reset, and any CSR write, starts a clearing sweep over all MAX_BASIC_BLOCKS
// entries that rewrites the tag RAM (entry 0 becomes one free top-order
// block); busy stays high until it ends. CSRs: 0 basic_block_shift,
// 1 order_count, at byte addresses 0 and 4; write only while idle.

module buddy_block_allocator
   import bba_pkg::*;
#(
   parameter int MAX_BASIC_BLOCKS = MAX_BASIC_BLOCKS_DEF,
   parameter int MAX_ORDERS       = MAX_ORDERS_DEF,
   parameter int HEADER_BYTES     = HEADER_BYTES_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire logic                req_mode,
   input  wire logic [ADDR_W-1:0]   req_request_bytes,
   input  wire logic [ADDR_W-1:0]   req_block_address,
   output logic                     rsp_valid,
   output logic [ADDR_W-1:0]        rsp_data_address,
   output logic [STATUS_W-1:0]      rsp_status,
   input  wire logic                psel,
   input  wire logic                penable,
   input  wire logic                pwrite,
   input  wire logic [2:0]          paddr,
   input  wire logic [31:0]         pwdata,
   output logic [31:0]              prdata,
   output logic                     pready
);

   localparam int IW       = $clog2(MAX_BASIC_BLOCKS);
   localparam int WW       = IW + 1;
   localparam int LOG_MAXB = $clog2(MAX_BASIC_BLOCKS + 1) - 1;
   localparam int ORD_LIM  = LOG_MAXB + 1;
   localparam int SUM_W    = 17;
   localparam int NEED_W   = ADDR_W + 1;
   localparam int CMP_W    = 31;

   // ---------------- CSRs ----------------
   logic [SHIFT_W-1:0] shift_ff;
   logic [ORD_W-1:0]   orders_ff;
   logic               csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff  <= 5'd7;
         orders_ff <= 4'd9;
      end else if (csr_write) begin
         unique case (paddr[2])
            REG_SHIFT:  shift_ff  <= pwdata[SHIFT_W-1:0];
            REG_ORDERS: orders_ff <= pwdata[ORD_W-1:0];
            default:    ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_SHIFT:  prdata = {{(32-SHIFT_W){1'b0}}, shift_ff};
         REG_ORDERS: prdata = {{(32-ORD_W){1'b0}}, orders_ff};
         default:    prdata = '0;
      endcase
   end

   // effective geometry: clamped shift and order count
   logic [SHIFT_W-1:0] s_eff;
   logic [ORD_W-1:0]   n_eff;
   logic [ORD_W-1:0]   n_top;      // n_eff - 1
   logic [WW-1:0]      nblocks;

   always_comb begin
      logic [ORD_W-1:0] n;
      logic [ORD_W:0]   lim_s;
      s_eff = shift_ff;
      if (s_eff < SHIFT_MIN) s_eff = SHIFT_MIN;
      if (s_eff > SHIFT_MAX) s_eff = SHIFT_MAX;
      n = orders_ff;
      if (n < 4'd1) n = 4'd1;
      if (n > ORD_W'(MAX_ORDERS)) n = ORD_W'(MAX_ORDERS);
      if (n > ORD_W'(ORD_LIM)) n = ORD_W'(ORD_LIM);
      // pool must fit 24 bits: s + n - 1 <= 24
      lim_s = 5'd25 - s_eff;
      if ({1'b0, n} > lim_s) n = lim_s[ORD_W-1:0];
      n_eff   = n;
      n_top   = n - 4'd1;
      nblocks = WW'(1) << n_top;
   end

   // ---------------- tag RAM ----------------
   logic             wr_en;
   logic [IW-1:0]    wr_addr;
   logic [TAG_W-1:0] wr_data;
   logic [IW-1:0]    rd_addr;
   logic [TAG_W-1:0] rd_data;

   bba_ram #(
      .WIDTH (TAG_W),
      .DEPTH (MAX_BASIC_BLOCKS)
   ) u_tags (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // ---------------- control ----------------
   state_type          state_ff, state_in;
   logic [IW-1:0]      clr_ff, clr_in;
   logic [ADDR_W-1:0]  req_bytes_ff, req_bytes_in;
   logic [ADDR_W-1:0]  req_addr_ff, req_addr_in;
   logic [WW-1:0]      walk_ff, walk_in;
   logic [IW-1:0]      best_ff, best_in;       // chosen block / freed block index
   logic [ORD_W-1:0]   best_ord_ff, best_ord_in;
   logic               found_ff, found_in;
   logic [ORD_W-1:0]   k_ff, k_in;             // wanted order
   logic [ORD_W-1:0]   ord_ff, ord_in;         // split / merge order
   logic               rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]  rsp_addr_ff, rsp_addr_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_bytes_ff  <= req_bytes_in;
      req_addr_ff   <= req_addr_in;
      walk_ff       <= walk_in;
      best_ff       <= best_in;
      best_ord_ff   <= best_ord_in;
      found_ff      <= found_in;
      k_ff          <= k_in;
      ord_ff        <= ord_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_data_address = rsp_addr_ff;
   assign rsp_status       = rsp_status_ff;

   always_comb begin
      logic [NEED_W-1:0] need;
      logic [NEED_W-1:0] pool;
      logic [ORD_W-1:0]  k;
      logic              hit;
      logic [ADDR_W-1:0] off;
      logic [ADDR_W-1:0] mask;
      logic [ADDR_W-1:0] bidx;
      logic              bad;
      logic [ORD_W-1:0]  t_ord;
      logic              t_start;
      logic              t_free;
      logic [SUM_W-1:0]  wsum;
      logic              wend;
      logic [IW-1:0]     bud;

      state_in      = state_ff;
      clr_in        = clr_ff;
      req_bytes_in  = req_bytes_ff;
      req_addr_in   = req_addr_ff;
      walk_in       = walk_ff;
      best_in       = best_ff;
      best_ord_in   = best_ord_ff;
      found_in      = found_ff;
      k_in          = k_ff;
      ord_in        = ord_ff;
      rsp_valid_in  = 1'b0;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = '0;
      rd_addr       = '0;

      t_ord   = rd_data[ORD_W-1:0];
      t_start = rd_data[TAG_START_BIT];
      t_free  = rd_data[TAG_FREE_BIT];

      // size class of the allocate
      need = NEED_W'(req_bytes_ff) + NEED_W'(HEADER_BYTES);
      pool = NEED_W'(1) << (s_eff + SHIFT_W'(n_top));
      k    = '0;
      hit  = 1'b0;
      for (int kk = 0; kk < MAX_ORDERS; kk++) begin
         if (!hit && (CMP_W'(need) <= (CMP_W'(1) << (s_eff + SHIFT_W'(kk))))) begin
            k   = ORD_W'(kk);
            hit = 1'b1;
         end
      end

      // free address decode
      off  = req_addr_ff - ADDR_W'(HEADER_BYTES);
      mask = (ADDR_W'(1) << s_eff) - ADDR_W'(1);
      bidx = off >> s_eff;
      bad  = (req_addr_ff < ADDR_W'(HEADER_BYTES)) || ((off & mask) != '0) ||
             (bidx >= ADDR_W'(nblocks));

      // walk step: skip a whole block when a start tag is seen
      if (t_start) begin
         if (t_ord > ORD_W'(IW)) wsum = SUM_W'(nblocks);
         else                    wsum = SUM_W'(walk_ff) + (SUM_W'(1) << t_ord);
      end else begin
         wsum = SUM_W'(walk_ff) + SUM_W'(1);
      end
      wend = (wsum >= SUM_W'(nblocks));

      bud = best_ff ^ (IW'(1) << ord_ff);

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            if (clr_ff == '0) begin
               wr_data = {1'b1, 1'b1, n_top};
            end
            clr_in = clr_ff + IW'(1);
            if (clr_ff == IW'(MAX_BASIC_BLOCKS - 1)) begin
               clr_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               req_bytes_in = req_request_bytes;
               req_addr_in  = req_block_address;
               state_in     = req_mode ? ST_F_PREP : ST_A_PREP;
            end
         end
         ST_A_PREP: begin
            if (need > pool) begin
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = '0;
               rsp_status_in = STATUS_TOO_LARGE;
               state_in      = ST_IDLE;
            end else begin
               k_in     = k;
               found_in = 1'b0;
               walk_in  = '0;
               rd_addr  = '0;
               state_in = ST_A_EVAL;
            end
         end
         ST_A_EVAL: begin
            // lowest order first, then lowest address
            if (t_start && t_free && (t_ord >= k_ff) &&
                (!found_ff || (t_ord < best_ord_ff))) begin
               found_in    = 1'b1;
               best_in     = walk_ff[IW-1:0];
               best_ord_in = t_ord;
            end
            walk_in = wsum[WW-1:0];
            rd_addr = wsum[IW-1:0];
            if (wend) state_in = ST_A_END;
         end
         ST_A_END: begin
            if (!found_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = '0;
               rsp_status_in = STATUS_NO_BLOCK;
               state_in      = ST_IDLE;
            end else begin
               ord_in   = best_ord_ff;
               state_in = ST_A_SPLIT;
            end
         end
         ST_A_SPLIT: begin
            wr_en = 1'b1;
            if (ord_ff > k_ff) begin
               // upper half becomes a free block one order down
               wr_addr = best_ff + (IW'(1) << (ord_ff - ORD_W'(1)));
               wr_data = {1'b1, 1'b1, ord_ff - ORD_W'(1)};
               ord_in  = ord_ff - ORD_W'(1);
            end else begin
               wr_addr       = best_ff;
               wr_data       = {1'b1, 1'b0, k_ff};
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = (ADDR_W'(best_ff) << s_eff) + ADDR_W'(HEADER_BYTES);
               rsp_status_in = STATUS_OK;
               state_in      = ST_IDLE;
            end
         end
         ST_F_PREP: begin
            if (bad) begin
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = '0;
               rsp_status_in = STATUS_BAD_FREE;
               state_in      = ST_IDLE;
            end else begin
               best_in  = bidx[IW-1:0];
               rd_addr  = bidx[IW-1:0];
               state_in = ST_F_CHECK;
            end
         end
         ST_F_CHECK: begin
            // must be the start of an allocated block
            if (!t_start || t_free) begin
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = '0;
               rsp_status_in = STATUS_BAD_FREE;
               state_in      = ST_IDLE;
            end else begin
               ord_in   = t_ord;
               state_in = ST_F_LOOP;
            end
         end
         ST_F_LOOP: begin
            if ((ord_ff + ORD_W'(1)) < n_eff) begin
               rd_addr  = bud;
               state_in = ST_F_MERGE;
            end else begin
               state_in = ST_F_WRITE;
            end
         end
         ST_F_MERGE: begin
            if (t_start && t_free && (t_ord == ord_ff)) begin
               // clear the upper tag, keep the lower as merged start
               wr_en   = 1'b1;
               wr_addr = (bud > best_ff) ? bud : best_ff;
               wr_data = '0;
               if (bud < best_ff) best_in = bud;
               ord_in   = ord_ff + ORD_W'(1);
               state_in = ST_F_LOOP;
            end else begin
               state_in = ST_F_WRITE;
            end
         end
         ST_F_WRITE: begin
            wr_en         = 1'b1;
            wr_addr       = best_ff;
            wr_data       = {1'b1, 1'b1, ord_ff};
            rsp_valid_in  = 1'b1;
            rsp_addr_in   = '0;
            rsp_status_in = STATUS_OK;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // any CSR write reinitializes the pool
      if (csr_write) begin
         clr_in   = '0;
         state_in = ST_CLEAR;
      end
   end

endmodule

`default_nettype wire

[dv/bba_checker.sv]
`timescale 1ns / 1ps

module bba_checker
   import bba_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic                busy,
   input  wire logic                req_mode,
   input  wire logic [ADDR_W-1:0]   req_request_bytes,
   input  wire logic [ADDR_W-1:0]   req_block_address,
   input  wire logic                rsp_valid,
   input  wire logic [ADDR_W-1:0]   rsp_data_address,
   input  wire logic [STATUS_W-1:0] rsp_status,
   input  wire logic                psel,
   input  wire logic                penable,
   input  wire logic                pwrite,
   input  wire logic [2:0]          paddr,
   input  wire logic [31:0]         pwdata,
   input  wire logic                pready,
   output int                       fail_count,
   output int                       pending
);

   typedef struct packed {
      logic [ADDR_W-1:0] data_address;
      status_type        status;
   } grant_type;

   logic [TAG_W-1:0]   tags [MAX_BASIC_BLOCKS_DEF];
   logic [SHIFT_W-1:0] shift_reg;
   logic [ORD_W-1:0]   orders_reg;
   grant_type          grants_due [$];

   function automatic int used_shift();
      int s;
      s = shift_reg;
      if (s < SHIFT_MIN) s = SHIFT_MIN;
      if (s > SHIFT_MAX) s = SHIFT_MAX;
      return s;
   endfunction

   function automatic int used_orders();
      int n, s;
      s = used_shift();
      n = orders_reg;
      if (n < 1) n = 1;
      if (n > MAX_ORDERS_DEF) n = MAX_ORDERS_DEF;
      while (n > 1 && ((1 << (n - 1)) > MAX_BASIC_BLOCKS_DEF || s + n - 1 > ADDR_W))
         n--;
      return n;
   endfunction

   function automatic logic [TAG_W-1:0] mk_tag(logic free_blk, int ord);
      mk_tag = '0;
      mk_tag[TAG_START_BIT] = 1'b1;
      mk_tag[TAG_FREE_BIT]  = free_blk;
      mk_tag[ORD_W-1:0]     = ord[ORD_W-1:0];
   endfunction

   function automatic logic is_free_start(logic [TAG_W-1:0] t, int ord);
      return t[TAG_START_BIT] && t[TAG_FREE_BIT] && (t[ORD_W-1:0] == ord);
   endfunction

   task automatic clear_pool();
      foreach (tags[i]) tags[i] = '0;
      tags[0] = mk_tag(1'b1, used_orders() - 1);
   endtask

   // allocate: smallest fitting order, lowest free block, split down
   task automatic grant_alloc(logic [ADDR_W-1:0] bytes, output grant_type g);
      int sh, n, nb, k, j, idx;
      longint need, pool;
      logic found;
      sh = used_shift();
      n = used_orders();
      nb = 1 << (n - 1);
      need = longint'(bytes) + HEADER_BYTES_DEF;
      pool = longint'(nb) << sh;
      g = '{data_address: '0, status: STATUS_OK};
      found = 1'b0;
      idx = 0;
      k = 0;
      if (need > pool) begin
         g.status = STATUS_TOO_LARGE;
         return;
      end
      while ((longint'(1) << (sh + k)) < need) k++;
      for (j = k; j < n && !found; j++) begin
         for (idx = 0; idx < nb; idx += (1 << j)) begin
            if (is_free_start(tags[idx], j)) begin
               found = 1'b1;
               break;
            end
         end
         if (found) break;
      end
      if (!found) begin
         g.status = STATUS_NO_BLOCK;
         return;
      end
      while (j > k) begin
         j--;
         tags[idx + (1 << j)] = mk_tag(1'b1, j);
      end
      tags[idx] = mk_tag(1'b0, k);
      g.data_address = ADDR_W'((longint'(idx) << sh) + HEADER_BYTES_DEF);
   endtask

   // free: validate, then merge with equal-order free buddies
   task automatic release_block(logic [ADDR_W-1:0] addr, output grant_type g);
      int sh, n, nb, idx, ord, bud;
      longint off, bidx;
      sh = used_shift();
      n = used_orders();
      nb = 1 << (n - 1);
      g = '{data_address: '0, status: STATUS_BAD_FREE};
      if (addr < HEADER_BYTES_DEF) return;
      off = longint'(addr) - HEADER_BYTES_DEF;
      if ((off & ((longint'(1) << sh) - 1)) != 0) return;
      bidx = off >> sh;
      if (bidx >= nb) return;
      idx = int'(bidx);
      if (!tags[idx][TAG_START_BIT] || tags[idx][TAG_FREE_BIT]) return;
      ord = tags[idx][ORD_W-1:0];
      while (ord + 1 < n) begin
         bud = idx ^ (1 << ord);
         if (!is_free_start(tags[bud], ord)) break;
         tags[idx > bud ? idx : bud] = '0;
         if (bud < idx) idx = bud;
         ord++;
      end
      tags[idx] = mk_tag(1'b1, ord);
      g.status = STATUS_OK;
   endtask

   assign pending = grants_due.size();

   always @(posedge clock) begin
      grant_type g, want;
      if (reset) begin
         shift_reg  = 5'd7;
         orders_reg = 4'd9;
         clear_pool();
         grants_due.delete();
         fail_count <= 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            if (paddr[2] == REG_SHIFT) shift_reg = pwdata[SHIFT_W-1:0];
            else                       orders_reg = pwdata[ORD_W-1:0];
            clear_pool();
         end
         if (start && !busy) begin
            if (req_mode) release_block(req_block_address, g);
            else          grant_alloc(req_request_bytes, g);
            grants_due.push_back(g);
         end
         if (rsp_valid) begin
            if (grants_due.size() == 0) begin
               if (fail_count < 10)
                  $display("%0t: unexpected result addr=%h status=%0d",
                           $realtime, rsp_data_address, rsp_status);
               fail_count <= fail_count + 1;
            end else begin
               want = grants_due.pop_front();
               if (want.data_address !== rsp_data_address || want.status !== rsp_status) begin
                  if (fail_count < 10)
                     $display("%0t: mismatch exp addr=%h status=%0d got addr=%h status=%0d",
                              $realtime, want.data_address, want.status,
                              rsp_data_address, rsp_status);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
   import bba_pkg::*;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   logic              req_mode;
   logic [ADDR_W-1:0] req_request_bytes;
   logic [ADDR_W-1:0] req_block_address;
   logic              rsp_valid;
   logic [ADDR_W-1:0] rsp_data_address;
   logic [STATUS_W-1:0] rsp_status;
   logic              psel, penable, pwrite;
   logic [2:0]        paddr;
   logic [31:0]       pwdata, prdata;
   logic              pready;
   int                fail_count, pending;

   // data addresses currently held by granted allocations
   logic [ADDR_W-1:0] live_blocks [$];
   int                pool_shift, pool_orders;

   buddy_block_allocator i_dut (
      .clock, .reset, .start, .busy, .req_mode, .req_request_bytes, .req_block_address,
      .rsp_valid, .rsp_data_address, .rsp_status,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   bba_checker i_checker (
      .clock, .reset, .start, .busy, .req_mode, .req_request_bytes, .req_block_address,
      .rsp_valid, .rsp_data_address, .rsp_status,
      .psel, .penable, .pwrite, .paddr, .pwdata, .pready, .fail_count, .pending
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // hard stop: worst case is far below this
   initial begin
      #20_000_000;
      $display("FAIL");
      $finish;
   end

   // one transaction: random gap, hold start until taken, then wait for the answer
   task automatic issue(logic mode, logic [ADDR_W-1:0] bytes, logic [ADDR_W-1:0] addr);
      int gap;
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
      repeat (gap) @(posedge clock);
      req_mode          <= mode;
      req_request_bytes <= bytes;
      req_block_address <= addr;
      start             <= 1'b1;
      do @(posedge clock); while (busy);
      start <= 1'b0;
      do @(posedge clock); while (!rsp_valid);
      if (!mode && rsp_status == STATUS_OK) live_blocks.push_back(rsp_data_address);
   endtask

   // register write while idle; the pool restarts empty
   task automatic csr_write(logic reg_idx, logic [31:0] value);
      do @(posedge clock); while (busy);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      paddr   <= {reg_idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      live_blocks.delete();
      if (reg_idx == REG_SHIFT) pool_shift = value[SHIFT_W-1:0];
      else                      pool_orders = value[ORD_W-1:0];
      repeat (2) @(posedge clock);
   endtask

   function automatic int pool_log2();
      int s, n;
      s = pool_shift < 5 ? 5 : (pool_shift > 16 ? 16 : pool_shift);
      n = pool_orders < 1 ? 1 : (pool_orders > 9 ? 9 : pool_orders);
      return s + n - 1;
   endfunction

   task automatic free_live();
      int i;
      logic [ADDR_W-1:0] a;
      i = $urandom_range(0, live_blocks.size() - 1);
      a = live_blocks[i];
      live_blocks.delete(i);
      issue(1'b1, ADDR_W'($urandom), a);
   endtask

   // mostly well-formed alloc/free traffic, some junk and bad frees
   task automatic random_phase(int items);
      int p, r;
      logic [ADDR_W-1:0] a;
      for (int n = 0; n < items; n++) begin
         p = pool_log2();
         r = $urandom_range(0, 99);
         if (r < 45)
            issue(1'b0, ADDR_W'($urandom_range(0, (1 << ($urandom_range(0, p))))),
                  ADDR_W'($urandom));
         else if (r < 85 && live_blocks.size() > 0)
            free_live();
         else if (r < 90)
            issue(1'b0, ADDR_W'($urandom), ADDR_W'($urandom));
         else if (r < 94 && live_blocks.size() > 0) begin
            // double free
            a = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
            issue(1'b1, ADDR_W'($urandom), a);
            issue(1'b1, ADDR_W'($urandom), a);
         end else if (r < 97)
            issue(1'b1, ADDR_W'($urandom), ADDR_W'($urandom));
         else
            issue(1'b1, ADDR_W'($urandom),
                  ADDR_W'(16 + ($urandom_range(0, 1 << p) & ~32'h1F)));
      end
   endtask

   initial begin
      reset             <= 1'b1;
      start             <= 1'b0;
      req_mode          <= 1'b0;
      req_request_bytes <= '0;
      req_block_address <= '0;
      psel              <= 1'b0;
      penable           <= 1'b0;
      pwrite            <= 1'b0;
      paddr             <= '0;
      pwdata            <= '0;
      pool_shift  = 7;
      pool_orders = 9;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, errors, full pool, merging
      issue(1'b0, 24'hFFFFFF, 24'h000000);
      issue(1'b0, 24'd0, 24'hFFFFFF);
      issue(1'b0, 24'd112, 24'd0);
      issue(1'b0, 24'd113, 24'd0);
      issue(1'b1, 24'hFFFFFF, 24'd0);
      issue(1'b1, 24'd0, 24'd15);
      issue(1'b1, 24'd0, 24'd17);
      issue(1'b1, 24'd0, 24'hFFFFFF);
      issue(1'b1, 24'd0, 24'd32784);
      issue(1'b1, 24'd0, 24'd16);
      issue(1'b1, 24'd0, 24'd16);
      issue(1'b1, 24'd0, 24'd272);
      issue(1'b1, 24'd0, 24'd528);
      issue(1'b0, 24'd32752, 24'd0);
      issue(1'b0, 24'd32753, 24'd0);
      issue(1'b0, 24'd0, 24'd0);
      issue(1'b1, 24'd0, 24'd16);
      issue(1'b0, 24'd32752, 24'd0);
      issue(1'b0, 24'd1, 24'd0);
      while (live_blocks.size() > 0) free_live();

      // several settings, extremes included; every write clears the pool
      random_phase(200);
      csr_write(REG_SHIFT, 32'd5);
      random_phase(200);
      csr_write(REG_SHIFT, 32'hFFFF_FFF0);
      random_phase(150);
      csr_write(REG_ORDERS, 32'd1);
      random_phase(60);
      csr_write(REG_SHIFT, 32'd0);
      csr_write(REG_ORDERS, 32'd15);
      random_phase(200);
      csr_write(REG_ORDERS, 32'd0);
      random_phase(60);
      csr_write(REG_ORDERS, 32'd3);
      csr_write(REG_SHIFT, 32'd31);
      random_phase(150);
      csr_write(REG_SHIFT, 32'd10);
      csr_write(REG_ORDERS, 32'd5);
      random_phase(250);
      csr_write(REG_SHIFT, 32'd6);
      csr_write(REG_ORDERS, 32'd9);
      random_phase(250);

      // drain, then a short settle before the verdict
      for (int w = 0; w < 2000 && pending != 0; w++) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
